[rtl/htbd_pkg.sv]
// Shared sizes, field codes and the child-entry layout for the prefix-code trie decoder.
// No dependencies; imported by the top level and the testbench.
`default_nettype none

package htbd_pkg;

    localparam int NODE_COUNT   = 256;
    localparam int SYMBOL_COUNT = 257;
    localparam int MAX_CODE_LEN = 30;

    localparam int REQ_W    = 2;
    localparam int SYM_W    = 9;
    localparam int CODE_W   = 30;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;

    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int FREE_W     = $clog2(NODE_COUNT + 1);
    localparam int SYM_ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int CHILD_W    = KIND_W + SYM_W;
    localparam int ENTRY_W    = 2 * CHILD_W;
    localparam int SHIFT_W    = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

    localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BIT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NODE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LEAF  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DECODED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD_OK    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONFLICT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_LD_EVAL  = 5'b00010,
        S_BIT_EVAL = 5'b00100,
        S_LEN_WAIT = 5'b01000,
        S_RESP     = 5'b10000
    } state_t;

endpackage

`default_nettype wire

[rtl/htbd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/huffman_trie_build_and_bit_decode_unit.sv]
// Prefix-code trie builder and bit-serial decoder, top level.
// Depends on htbd_pkg and two htbd_ram instances (child entries, leaf lengths).
//
// Usage:
//   Request channel (req_valid / req_stall): req_type selects a code load, one encoded
//   bit, or end of data. Result channel (res_valid / res_stall): status, symbol_out,
//   length_out, at most one result per request.
//   A load walks its code one bit per cycle through a shift register, then answers;
//   a rejected load answers without a walk. A bit request that lands on an internal
//   node gives no result. A leaf answers once its leaf length has been read; an empty
//   child answers with invalid status. An end in mid code answers; an end at the root
//   or an unknown request gives no result. The child RAM's registered read, one trie
//   level per read, paces the load walk and the bit requests.
//   Reset clears the child valid flags at once (no clearing pass), puts the walk at
//   the root and the free-node pointer at one. Leaf lengths are not cleared.
//   A stalled result holds in the output register; the block takes the next request
//   meanwhile, stalls requests while it works on one, and holds a further result while the output is full.
`default_nettype none

module huffman_trie_build_and_bit_decode_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire logic [htbd_pkg::REQ_W-1:0]    req_type,
    input  wire logic [htbd_pkg::SYM_W-1:0]    symbol,
    input  wire logic [htbd_pkg::CODE_W-1:0]   code_word,
    input  wire logic [htbd_pkg::LEN_W-1:0]    code_len,
    input  wire logic                          bit_value,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic      [htbd_pkg::STATUS_W-1:0] status,
    output logic      [htbd_pkg::SYM_W-1:0]    symbol_out,
    output logic      [htbd_pkg::LEN_W-1:0]    length_out
);

    import htbd_pkg::*;

    localparam logic [LEN_W:0]  MAX_LEN_L   = (LEN_W + 1)'(MAX_CODE_LEN);
    localparam logic [LEN_W:0]  SHIFT_W_L   = (LEN_W + 1)'(SHIFT_W);
    localparam logic [SYM_W:0]  SYM_LIMIT   = (SYM_W + 1)'(SYMBOL_COUNT);
    localparam logic [FREE_W-1:0] FREE_LIMIT = FREE_W'(NODE_COUNT);

    state_t state_reg, state_next;

    logic [NODE_COUNT-1:0] valid_reg;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [NODE_W-1:0]     walk_reg, walk_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [LEN_W-1:0]      remain_reg, remain_next;
    logic [SHIFT_W-1:0]    code_reg, code_next;
    logic [SYM_W-1:0]      sym_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  bit_reg;

    logic [STATUS_W-1:0]   pend_status_reg, pend_status_next;
    logic [SYM_W-1:0]      pend_sym_reg, pend_sym_next;
    logic [LEN_W-1:0]      pend_len_reg, pend_len_next;

    logic                  res_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SYM_W-1:0]      symbol_out_reg;
    logic [LEN_W-1:0]      length_out_reg;

    logic                  accept;
    logic                  out_free;
    logic                  bad_load;
    logic [LEN_W:0]        align_amt;
    logic [SHIFT_W-1:0]    code_aligned;

    logic                  child_wr_en;
    logic [ENTRY_W-1:0]    child_wr_data;
    logic [NODE_W-1:0]     child_rd_addr;
    logic [ENTRY_W-1:0]    child_rd_data;
    logic                  leaf_wr_en;
    logic                  leaf_rd_en;
    logic [SYM_ADDR_W-1:0] leaf_rd_addr;
    logic [LEN_W-1:0]      leaf_rd_data;

    logic [NODE_W-1:0]     node_sel;
    logic                  dir;
    logic [ENTRY_W-1:0]    ent_word;
    logic [CHILD_W-1:0]    ent;
    logic [KIND_W-1:0]     kind;
    logic [SYM_W-1:0]      val;
    logic [CHILD_W-1:0]    new_ent;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;

    assign bad_load = (code_len == '0) || ({1'b0, code_len} > MAX_LEN_L)
                   || ({1'b0, symbol} >= SYM_LIMIT);
    assign align_amt    = SHIFT_W_L - {1'b0, code_len};
    assign code_aligned = SHIFT_W'(code_word) << align_amt;

    // Child entry of the node under evaluation; a node never written reads as empty.
    assign node_sel = (state_reg == S_BIT_EVAL) ? walk_reg : node_reg;
    assign dir      = (state_reg == S_BIT_EVAL) ? bit_reg : code_reg[SHIFT_W-1];
    assign ent_word = valid_reg[node_sel] ? child_rd_data : '0;
    assign ent      = dir ? ent_word[ENTRY_W-1:CHILD_W] : ent_word[CHILD_W-1:0];
    assign kind     = ent[CHILD_W-1:SYM_W];
    assign val      = ent[SYM_W-1:0];
    assign child_wr_data = dir ? {new_ent, ent_word[CHILD_W-1:0]}
                               : {ent_word[ENTRY_W-1:CHILD_W], new_ent};
    assign leaf_rd_addr  = val[SYM_ADDR_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        walk_next        = walk_reg;
        free_next        = free_reg;
        node_next        = node_reg;
        remain_next      = remain_reg;
        code_next        = code_reg;
        pend_status_next = pend_status_reg;
        pend_sym_next    = pend_sym_reg;
        pend_len_next    = pend_len_reg;
        child_wr_en      = 1'b0;
        leaf_wr_en       = 1'b0;
        leaf_rd_en       = 1'b0;
        new_ent          = {KIND_EMPTY, {SYM_W{1'b0}}};
        child_rd_addr    = walk_reg;

        case (state_reg)
            S_IDLE:
            begin
                child_rd_addr = (req_type == REQ_LOAD) ? '0 : walk_reg;
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD:
                        begin
                            if (bad_load)
                            begin
                                pend_status_next = ST_CONFLICT;
                                pend_sym_next    = '0;
                                pend_len_next    = '0;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                node_next   = '0;
                                code_next   = code_aligned;
                                remain_next = code_len - LEN_W'(1);
                                state_next  = S_LD_EVAL;
                            end
                        end
                        REQ_BIT:
                        begin
                            state_next = S_BIT_EVAL;
                        end
                        REQ_END:
                        begin
                            if (walk_reg != '0)
                            begin
                                walk_next        = '0;
                                pend_status_next = ST_INCOMPLETE;
                                pend_sym_next    = '0;
                                pend_len_next    = '0;
                                state_next       = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LD_EVAL:
            begin
                pend_sym_next = '0;
                pend_len_next = '0;
                if (remain_reg != '0)
                begin
                    case (kind)
                        KIND_EMPTY:
                        begin
                            if (free_reg >= FREE_LIMIT)
                            begin
                                pend_status_next = ST_EXHAUSTED;
                                state_next       = S_RESP;
                            end
                            else
                            begin
                                // Hang a fresh node off this child and descend into it.
                                new_ent       = {KIND_NODE, SYM_W'(free_reg)};
                                child_wr_en   = 1'b1;
                                node_next     = free_reg[NODE_W-1:0];
                                free_next     = free_reg + FREE_W'(1);
                                child_rd_addr = node_next;
                                code_next     = code_reg << 1;
                                remain_next   = remain_reg - LEN_W'(1);
                            end
                        end
                        KIND_NODE:
                        begin
                            node_next     = val[NODE_W-1:0];
                            child_rd_addr = node_next;
                            code_next     = code_reg << 1;
                            remain_next   = remain_reg - LEN_W'(1);
                        end
                        default:
                        begin
                            // Path runs through an existing leaf.
                            pend_status_next = ST_CONFLICT;
                            state_next       = S_RESP;
                        end
                    endcase
                end
                else
                begin
                    if (kind != KIND_EMPTY)
                    begin
                        pend_status_next = ST_CONFLICT;
                    end
                    else
                    begin
                        new_ent          = {KIND_LEAF, sym_reg};
                        child_wr_en      = 1'b1;
                        leaf_wr_en       = 1'b1;
                        pend_status_next = ST_LOAD_OK;
                    end
                    state_next = S_RESP;
                end
            end
            S_BIT_EVAL:
            begin
                case (kind)
                    KIND_NODE:
                    begin
                        walk_next  = val[NODE_W-1:0];
                        state_next = S_IDLE;
                    end
                    KIND_LEAF:
                    begin
                        walk_next        = '0;
                        pend_status_next = ST_DECODED;
                        pend_sym_next    = val;
                        pend_len_next    = '0;
                        if ({1'b0, val} < SYM_LIMIT)
                        begin
                            leaf_rd_en = 1'b1;
                            state_next = S_LEN_WAIT;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    default:
                    begin
                        walk_next        = '0;
                        pend_status_next = ST_INVALID;
                        pend_sym_next    = '0;
                        pend_len_next    = '0;
                        state_next       = S_RESP;
                    end
                endcase
            end
            S_LEN_WAIT:
            begin
                pend_len_next = leaf_rd_data;
                state_next    = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            free_reg      <= FREE_W'(1);
            walk_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            free_reg  <= free_next;
            walk_reg  <= walk_next;
            // A freshly allocated node has never been written, so its flag is still clear.
            if (child_wr_en)
            begin
                valid_reg[node_reg] <= 1'b1;
            end
            if ((state_reg == S_RESP) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg        <= node_next;
        remain_reg      <= remain_next;
        code_reg        <= code_next;
        pend_status_reg <= pend_status_next;
        pend_sym_reg    <= pend_sym_next;
        pend_len_reg    <= pend_len_next;
        if (accept)
        begin
            sym_reg <= symbol;
            len_reg <= code_len;
            bit_reg <= bit_value;
        end
        if ((state_reg == S_RESP) && out_free)
        begin
            status_reg     <= pend_status_reg;
            symbol_out_reg <= pend_sym_reg;
            length_out_reg <= pend_len_reg;
        end
    end

    htbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NODE_COUNT)
    ) u_child_ram (
        .clk     (clk),
        .wr_en   (child_wr_en),
        .wr_addr (node_reg),
        .wr_data (child_wr_data),
        .rd_en   (1'b1),
        .rd_addr (child_rd_addr),
        .rd_data (child_rd_data)
    );

    htbd_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_leaf_len_ram (
        .clk     (clk),
        .wr_en   (leaf_wr_en),
        .wr_addr (sym_reg[SYM_ADDR_W-1:0]),
        .wr_data (len_reg),
        .rd_en   (leaf_rd_en),
        .rd_addr (leaf_rd_addr),
        .rd_data (leaf_rd_data)
    );

    assign res_valid  = res_valid_reg;
    assign status     = status_reg;
    assign symbol_out = symbol_out_reg;
    assign length_out = length_out_reg;

`ifndef SYNTHESIS
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= FREE_LIMIT)
        else $error("free-node pointer beyond node count");

    a_load_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LD_EVAL) |=> $stable(walk_reg))
        else $error("load step moved the decode walk");

    a_end_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_END) && (walk_reg != '0))
        |=> ((walk_reg == '0) && (state_reg == S_RESP)))
        else $error("end request in mid code did not return to root");

    a_resp_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RESP) && res_valid_reg && res_stall) |=> (state_reg == S_RESP))
        else $error("pending result dropped while output held");

    a_no_write_outside_load: assert property (@(posedge clk) disable iff (!rst_n)
        (child_wr_en || leaf_wr_en) |-> (state_reg == S_LD_EVAL))
        else $error("trie written outside a load walk");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for huffman_trie_build_and_bit_decode_unit: loads prefix codes,
// decodes bit streams built from them and checks every result against a trie predictor.
// Depends on htbd_pkg and the RTL of the top level only.

module testbench;

    import htbd_pkg::*;

    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

    localparam int unsigned TOTAL_ITEMS  = 1050;
    localparam int unsigned PHASE_ITEMS  = 350;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned LIMIT_CYCLES = 400000;

    class trie_decode_scoreboard;

        typedef struct packed {
            logic [KIND_W-1:0] kind;
            logic [SYM_W-1:0]  idx;
        } child_t;

        typedef struct packed {
            logic [STATUS_W-1:0] status;
            logic [SYM_W-1:0]    symbol;
            logic [LEN_W-1:0]    length;
        } decode_result_t;

        child_t            kids [NODE_COUNT][2];
        logic [LEN_W-1:0]  leaf_len [SYMBOL_COUNT];
        int unsigned       free_node;
        int unsigned       walk_node;
        decode_result_t    pending_results [$];
        logic [CODE_W-1:0] placed_code [$];
        int unsigned       placed_len [$];
        int unsigned       failures;

        function new();
            foreach (kids[n, d])
                kids[n][d] = '0;
            foreach (leaf_len[s])
                leaf_len[s] = '0;
            free_node = 1;
            walk_node = 0;
            failures  = 0;
        endfunction

        // Walk the code from its top bit, growing the trie; returns the load status.
        function logic [STATUS_W-1:0] place_code(logic [SYM_W-1:0] sym,
                                                 logic [CODE_W-1:0] code,
                                                 logic [LEN_W-1:0] len);
            int unsigned node;
            int          i;
            logic        dir;
            child_t      c;
            if (len == 0 || len > MAX_CODE_LEN || sym >= SYMBOL_COUNT)
                return ST_CONFLICT;
            node = 0;
            for (i = int'(len) - 1; i > 0; i--)
            begin
                dir = code[i];
                c   = kids[node][dir];
                if (c.kind == KIND_EMPTY)
                begin
                    // nodes taken earlier in this load stay in the trie
                    if (free_node >= NODE_COUNT)
                        return ST_EXHAUSTED;
                    kids[free_node][0] = '0;
                    kids[free_node][1] = '0;
                    kids[node][dir]    = {KIND_NODE, SYM_W'(free_node)};
                    node               = free_node;
                    free_node++;
                end
                else if (c.kind == KIND_NODE)
                    node = c.idx;
                else
                    return ST_CONFLICT;
            end
            dir = code[0];
            if (kids[node][dir].kind != KIND_EMPTY)
                return ST_CONFLICT;
            kids[node][dir] = {KIND_LEAF, sym};
            leaf_len[sym]   = len;
            placed_code.push_back(code);
            placed_len.push_back(len);
            return ST_LOAD_OK;
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [SYM_W-1:0] sym,
                                   logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                                   logic bit_in);
            decode_result_t r;
            child_t         c;
            r = '0;
            case (kind)
                REQ_LOAD:
                begin
                    r.status = place_code(sym, code, len);
                    pending_results.push_back(r);
                end
                REQ_BIT:
                begin
                    c = kids[walk_node][bit_in];
                    if (c.kind == KIND_NODE)
                    begin
                        walk_node = c.idx;
                        return;
                    end
                    if (c.kind == KIND_LEAF)
                    begin
                        r.status = ST_DECODED;
                        r.symbol = c.idx;
                        r.length = leaf_len[c.idx];
                    end
                    else
                        r.status = ST_INVALID;
                    walk_node = 0;
                    pending_results.push_back(r);
                end
                REQ_END:
                    if (walk_node != 0)
                    begin
                        walk_node = 0;
                        r.status  = ST_INCOMPLETE;
                        pending_results.push_back(r);
                    end
                default: ;
            endcase
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [SYM_W-1:0] sym,
                                   logic [LEN_W-1:0] len);
            decode_result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d symbol %0d length %0d", st, sym, len);
                failures++;
                return;
            end
            e = pending_results.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                failures++;
            end
            if (sym !== e.symbol)
            begin
                $error("symbol_out: expected %0d, got %0d", e.symbol, sym);
                failures++;
            end
            if (len !== e.length)
            begin
                $error("length_out: expected %0d, got %0d", e.length, len);
                failures++;
            end
        endfunction

    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    logic [REQ_W-1:0]    req_type    = '0;
    logic [SYM_W-1:0]    symbol      = '0;
    logic [CODE_W-1:0]   code_word   = '0;
    logic [LEN_W-1:0]    code_len    = '0;
    logic                bit_value   = 1'b0;
    logic                res_valid;
    logic                res_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0]    symbol_out;
    logic [LEN_W-1:0]    length_out;

    int unsigned send_idle   = 38;
    int unsigned recv_idle   = 73;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;

    trie_decode_scoreboard trie_sb;

    huffman_trie_build_and_bit_decode_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_len    (code_len),
        .bit_value   (bit_value),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .symbol_out  (symbol_out),
        .length_out  (length_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        res_stall = ($urandom_range(0, 99) < recv_idle);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("huffman_trie_build_and_bit_decode_unit verification failed");
            $finish;
        end
        else if (rst_n && res_valid && !res_stall)
            trie_sb.check_result(status, symbol_out, length_out);
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                                input logic bit_in);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_valid   = 1'b0;
            req_type    = REQ_W'($urandom);
            symbol      = SYM_W'($urandom);
            code_word   = CODE_W'($urandom);
            code_len    = LEN_W'($urandom);
            bit_value   = 1'($urandom);
            @(negedge clk);
        end
        req_valid   = 1'b1;
        req_type    = kind;
        symbol      = sym;
        code_word   = code;
        code_len    = len;
        bit_value   = bit_in;
        // hold the request until it is taken
        do
            @(posedge clk);
        while (req_stall);
        trie_sb.note_request(kind, sym, code, len, bit_in);
        if (kind != REQ_IGNORED)
            items_sent++;
        if (items_sent == PHASE_ITEMS)
        begin
            send_idle = 73;
            recv_idle = 38;
        end
        else if (items_sent == 2 * PHASE_ITEMS)
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic send_bit(input logic b);
        send_request(REQ_BIT, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom), b);
    endtask

    task automatic send_end();
        send_request(REQ_END, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                     1'($urandom));
    endtask

    task automatic send_ignored();
        send_request(REQ_IGNORED, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                     1'($urandom));
    endtask

    task automatic send_load(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
                             input logic [LEN_W-1:0] len);
        send_request(REQ_LOAD, sym, code, len, 1'($urandom));
    endtask

    // Send count bits of a placed code, starting first bits below its top bit.
    task automatic send_code_bits(input int unsigned idx, input int unsigned first,
                                  input int unsigned count);
        logic [CODE_W-1:0] cw;
        int unsigned       len;
        cw  = trie_sb.placed_code[idx];
        len = trie_sb.placed_len[idx];
        for (int unsigned k = first; k < first + count; k++)
            send_bit(cw[len - 1 - k]);
    endtask

    task automatic return_to_root();
        if (trie_sb.walk_node != 0)
            send_end();
    endtask

    task automatic send_random_load();
        int unsigned       len;
        int unsigned       pick;
        int unsigned       long_pct;
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  sym;
        // lean on long codes later on so the node pool runs dry
        long_pct = (items_sent > TOTAL_ITEMS / 2) ? 40 : 13;
        pick     = $urandom_range(0, 99);
        if (pick < 8)
            len = $urandom_range(0, 31);
        else if (pick < 8 + long_pct)
            len = $urandom_range(13, MAX_CODE_LEN);
        else
            len = $urandom_range(2, 12);
        code = CODE_W'($urandom);
        // keep most codes clear of the one-bit leaf on the right of the root
        if (len >= 1 && len <= MAX_CODE_LEN && $urandom_range(0, 9) != 0)
            code[len - 1] = 1'b0;
        if ($urandom_range(0, 9) == 0)
            sym = SYM_W'($urandom_range(SYMBOL_COUNT, 511));
        else
            sym = SYM_W'($urandom_range(0, SYMBOL_COUNT - 1));
        send_load(sym, code, LEN_W'(len));
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned idx;
        int unsigned len;
        int unsigned cut;
        int unsigned n;
        trie_sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_load(9'd256, 30'b1, 5'd1);
        send_load(9'd0, 30'b10, 5'd2);              // passes through a leaf
        send_load(9'd1, 30'b000, 5'd3);
        send_load(9'd2, 30'b000, 5'd3);             // leaf slot taken
        send_load(9'd3, 30'b00, 5'd2);              // slot holds an internal node
        send_load(9'd0, '1, 5'd0);
        send_load(9'd0, '1, 5'd31);
        send_load(9'd257, 30'b001, 5'd3);
        send_load(9'd255, 30'h1FFF_FFFF, 5'd30);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);
        send_end();                                 // end in mid code
        send_bit(1'b0);
        send_bit(1'b0);
        send_bit(1'b1);                             // empty child
        send_ignored();
        send_end();                                 // end at the root
        // load in the middle of a walk leaves the walk alone
        send_bit(1'b0);
        send_load(9'd5, 30'b001, 5'd3);
        send_bit(1'b0);
        send_bit(1'b1);

        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                return_to_root();
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    idx = $urandom_range(0, trie_sb.placed_len.size() - 1);
                    send_code_bits(idx, 0, trie_sb.placed_len[idx]);
                end
                if ($urandom_range(0, 1) == 1)
                    send_end();
            end
            else if (pick < 65)
            begin
                repeat ($urandom_range(1, 8))
                    send_random_load();
            end
            else if (pick < 75)
            begin
                return_to_root();
                idx = $urandom_range(0, trie_sb.placed_len.size() - 1);
                len = trie_sb.placed_len[idx];
                if (len >= 2)
                begin
                    send_code_bits(idx, 0, $urandom_range(1, len - 1));
                    send_end();
                end
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 6))
                    send_bit(1'($urandom));
            end
            else if (pick < 93)
            begin
                // break a code in the middle, then carry on with its tail
                return_to_root();
                idx = $urandom_range(0, trie_sb.placed_len.size() - 1);
                len = trie_sb.placed_len[idx];
                if (len >= 2)
                begin
                    cut = $urandom_range(1, len - 1);
                    send_code_bits(idx, 0, cut);
                    case ($urandom_range(0, 2))
                        0: send_random_load();
                        1: send_ignored();
                        default: send_bit(~trie_sb.placed_code[idx][len - 1 - cut]);
                    endcase
                    send_code_bits(idx, cut, len - cut);
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: send_ignored();
                    1: send_end();
                    default: send_load(SYM_W'($urandom), CODE_W'($urandom),
                                       ($urandom_range(0, 1) == 1) ? 5'd31 : 5'd0);
                endcase
            end
        end

        @(negedge clk);
        req_valid = 1'b0;
        while (trie_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (trie_sb.failures == 0)
            $display("huffman_trie_build_and_bit_decode_unit verification clean");
        else
            $display("huffman_trie_build_and_bit_decode_unit verification failed");
        $finish;
    end

endmodule
